// ===== hw/rtl/tsfr_pkg.sv =====
package tsfr_pkg;

    localparam int BURST_LENGTH = 6;
    localparam int TRIM_COUNT   = 1;
    localparam int MIN_RAW      = 100;
    localparam int SAMPLE_BITS  = 12;

    localparam int TRIM_EFF  = (2 * TRIM_COUNT >= BURST_LENGTH) ?
                               (BURST_LENGTH - 1) / 2 : TRIM_COUNT;
    localparam int KEEP      = BURST_LENGTH - 2 * TRIM_EFF;
    localparam int POS_W     = $clog2(4 * BURST_LENGTH + 1);
    localparam int IDX_W     = $clog2(BURST_LENGTH);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(BURST_LENGTH + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE       = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [11:0] sample;
    } in_word_t;

    typedef struct packed {
        logic        stored;
        logic        pressed;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
    } out_word_t;

    typedef struct packed {
        logic load;      // accept input word, store sample
        logic pen_up;    // sample is pen up
        logic sort_step; // one pass of odd-even sort
        logic sum_init;
        logic sum_step;
        logic div_init;  // start burst divide by KEEP
        logic div_step;
        logic save_avg;  // latch average into pair register
        logic pix_init;  // start pixel conversion
        logic pix_step;
        logic emit;      // build report
        logic fail;      // report no touch
    } cmd_t;

    typedef struct packed {
        logic burst_done;
        logic [2:0] burst;     // 0..4, 1..4 while a burst is processed
        logic pair1_bad;
        logic pair2_bad;
        logic cnt_done;
    } sts_t;

endpackage

// ===== hw/rtl/tsfr_ctrl.sv =====
module tsfr_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  logic          in_opcode,
    input  tsfr_pkg::sts_t sts,
    output tsfr_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SORT = 8'b00000010,
        S_SUMI = 8'b00000100,
        S_SUM  = 8'b00001000,
        S_DIV  = 8'b00010000,
        S_SAVE = 8'b00100000,
        S_PIX  = 8'b01000000,
        S_EMIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   fail_reg, fail_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.pen_up = in_opcode;
                    if (in_opcode)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else if (sts.burst_done)
                    begin
                        cmd.sum_init = 1'b1;
                        state_next = S_SORT;
                    end
                end
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (sts.cnt_done)
                    state_next = S_SUMI;
            end
            S_SUMI:
            begin
                cmd.sum_init = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.cnt_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt_done)
                    state_next = S_SAVE;
            end
            S_SAVE:
            begin
                cmd.save_avg = 1'b1;
                if (sts.burst == 3'd2)
                begin
                    if (sts.pair1_bad)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_IDLE;
                end
                else if (sts.burst == 3'd4)
                begin
                    if (sts.pair2_bad)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        fail_next  = 1'b0;
                        cmd.pix_init = 1'b1;
                        state_next = S_PIX;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            S_PIX:
            begin
                cmd.pix_step = 1'b1;
                if (sts.cnt_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit = 1'b1;
                    cmd.fail = fail_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/tsfr_dp.sv =====
module tsfr_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tsfr_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [tsfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [11:0]                         in_sample,
    input  tsfr_pkg::cmd_t                      cmd,
    output tsfr_pkg::sts_t                      sts,
    output tsfr_pkg::out_word_t                 out_word
);

    localparam int BL  = tsfr_pkg::BURST_LENGTH;
    localparam int SB  = tsfr_pkg::SAMPLE_BITS;
    localparam int IW  = tsfr_pkg::IDX_W;
    localparam int SW  = tsfr_pkg::SUM_W;
    localparam int DIVN = 22; // numerator bits of |raw-off|*1000
    localparam int PQ_W = 22;

    logic [11:0] offset_x_reg, offset_y_reg, screen_w_reg, screen_h_reg;
    logic [11:0] agree_reg, move_reg;
    logic [15:0] scale_x_reg, scale_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= 12'd247;
            offset_y_reg <= 12'd3388;
            scale_x_reg  <= 16'd4421;
            scale_y_reg  <= 16'd6078;
            screen_w_reg <= 12'd800;
            screen_h_reg <= 12'd480;
            agree_reg    <= 12'd20;
            move_reg     <= 12'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tsfr_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data[11:0];
                tsfr_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data[11:0];
                tsfr_pkg::REG_SCALE_X:  scale_x_reg  <= cfg_data;
                tsfr_pkg::REG_SCALE_Y:  scale_y_reg  <= cfg_data;
                tsfr_pkg::REG_SCREEN_W: screen_w_reg <= cfg_data[11:0];
                tsfr_pkg::REG_SCREEN_H: screen_h_reg <= cfg_data[11:0];
                tsfr_pkg::REG_AGREE:    agree_reg    <= cfg_data[11:0];
                tsfr_pkg::REG_MOVE:     move_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // burst buffer, burst count
    logic [SB-1:0] buf_reg [BL];
    logic [IW-1:0] widx_reg;
    logic [2:0]    burst_reg;

    assign sts.burst_done = (widx_reg == IW'(BL - 1));
    assign sts.burst = burst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg  <= '0;
            burst_reg <= 3'd0;
        end
        else if (cmd.load)
        begin
            if (cmd.pen_up)
            begin
                widx_reg  <= '0;
                burst_reg <= 3'd0;
            end
            else if (widx_reg == IW'(BL - 1))
            begin
                widx_reg  <= '0;
                burst_reg <= burst_reg + 3'd1;
            end
            else
                widx_reg <= widx_reg + IW'(1);
        end
        else if (cmd.save_avg && (burst_reg == 3'd4 || (burst_reg == 3'd2 &&
                 sts.pair1_bad)))
            burst_reg <= 3'd0;
    end

    // sort by odd-even transposition, then sum, done by counters
    logic [4:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && !cmd.pen_up)
            buf_reg[widx_reg] <= in_sample[SB-1:0];
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < BL - 1; i++)
            begin
                if ((i % 2) == int'(cnt_reg[0]) && buf_reg[i] > buf_reg[i+1])
                begin
                    buf_reg[i]   <= buf_reg[i+1];
                    buf_reg[i+1] <= buf_reg[i];
                end
            end
        end
    end

    // pixel conversion: |raw-off|*1000 then restoring divide, both axes
    logic [11:0] px_num_x, px_num_y;
    logic [DIVN-1:0] nx_reg, ny_reg;
    logic [16:0]     rx_reg, ry_reg;
    logic [PQ_W-1:0] qx_reg, qy_reg;
    logic [11:0]     fpx_reg, fpy_reg, spx_reg, rawx_reg, rawy_reg;
    logic [12:0]     sumx, sumy;
    logic [SW-1:0]   avg;
    logic [16:0]     rx_sh, ry_sh;

    assign avg = quo_reg;

    always_comb
    begin
        sts.cnt_done = 1'b0;
        if (cmd.sort_step)
            sts.cnt_done = (cnt_reg == 5'(BL - 1));
        else if (cmd.sum_step)
            sts.cnt_done = (cnt_reg == 5'(tsfr_pkg::KEEP - 1));
        else if (cmd.div_step)
            sts.cnt_done = 1'b1;
        else if (cmd.pix_step)
            sts.cnt_done = (cnt_reg == 5'(DIVN - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.sum_init || cmd.div_init || cmd.pix_init || sts.cnt_done)
            cnt_reg <= '0;
        else if (cmd.sort_step || cmd.sum_step || cmd.div_step || cmd.pix_step)
            cnt_reg <= cnt_reg + 5'd1;
    end

    // sum of the kept samples, divided by their count, a power of two
    always_ff @(posedge clk)
    begin
        if (cmd.sum_init)
            sum_reg <= '0;
        else if (cmd.sum_step)
            sum_reg <= sum_reg +
                       SW'(buf_reg[IW'(tsfr_pkg::TRIM_EFF) + cnt_reg[IW-1:0]]);
        if (cmd.div_step)
            quo_reg <= sum_reg / SW'(tsfr_pkg::KEEP);
    end

    assign sumx = {1'b0, fpx_reg} + {1'b0, spx_reg};
    assign sumy = {1'b0, rawy_reg} + {1'b0, avg[11:0]};

    function automatic logic [11:0] adiff12(input logic [11:0] a, input logic [11:0] b);
        adiff12 = (a > b) ? a - b : b - a;
    endfunction

    assign sts.pair1_bad = (fpx_reg < 12'(tsfr_pkg::MIN_RAW)) ||
                           (avg[11:0] < 12'(tsfr_pkg::MIN_RAW));
    assign sts.pair2_bad = (spx_reg < 12'(tsfr_pkg::MIN_RAW)) ||
                           (avg[11:0] < 12'(tsfr_pkg::MIN_RAW)) ||
                           (adiff12(fpx_reg, spx_reg) >= agree_reg) ||
                           (adiff12(fpy_reg, avg[11:0]) >= agree_reg);

    assign px_num_x = adiff12(sumx[12:1], offset_x_reg);
    assign px_num_y = adiff12(sumy[12:1], offset_y_reg);
    assign rx_sh = {rx_reg[15:0], nx_reg[DIVN-1]};
    assign ry_sh = {ry_reg[15:0], ny_reg[DIVN-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.save_avg)
        begin
            case (burst_reg)
                3'd1: fpx_reg <= avg[11:0];
                3'd2: fpy_reg <= avg[11:0];
                3'd3: spx_reg <= avg[11:0];
                default: ;
            endcase
        end
        if (cmd.pix_init)
        begin
            rawx_reg <= sumx[12:1];
            rawy_reg <= sumy[12:1];
            nx_reg <= DIVN'(px_num_x) * DIVN'(1000);
            ny_reg <= DIVN'(px_num_y) * DIVN'(1000);
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (cmd.save_avg && burst_reg == 3'd3)
            rawy_reg <= rawy_reg;
        else if (cmd.pix_step)
        begin
            nx_reg <= {nx_reg[DIVN-2:0], 1'b0};
            ny_reg <= {ny_reg[DIVN-2:0], 1'b0};
            if (rx_sh >= {1'b0, scale_x_reg})
            begin
                rx_reg <= rx_sh - {1'b0, scale_x_reg};
                qx_reg <= {qx_reg[PQ_W-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= rx_sh;
                qx_reg <= {qx_reg[PQ_W-2:0], 1'b0};
            end
            if (ry_sh >= {1'b0, scale_y_reg})
            begin
                ry_reg <= ry_sh - {1'b0, scale_y_reg};
                qy_reg <= {qy_reg[PQ_W-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= ry_sh;
                qy_reg <= {qy_reg[PQ_W-2:0], 1'b0};
            end
        end
        if (cmd.save_avg && burst_reg == 3'd2)
            rawy_reg <= avg[11:0];
    end

    // report
    logic        lp_reg;
    logic [15:0] lx_reg, ly_reg;
    logic        touch;
    logic [15:0] px, py;
    logic [15:0] dx, dy;
    logic        stored;
    logic        x_off, y_off;

    // zero scale yields all-ones quotient from the divider, off screen
    assign x_off = (qx_reg >= PQ_W'(screen_w_reg));
    assign y_off = (qy_reg >= PQ_W'(screen_h_reg));
    assign touch = !cmd.fail && !x_off && !y_off;
    assign px = touch ? qx_reg[15:0] : 16'd0;
    assign py = touch ? qy_reg[15:0] : 16'd0;
    assign dx = (lx_reg > px) ? lx_reg - px : px - lx_reg;
    assign dy = (ly_reg > py) ? ly_reg - py : py - ly_reg;
    assign stored = (lp_reg != touch) || (dx > 16'(move_reg)) || (dy > 16'(move_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= 1'b0;
            lx_reg <= '0;
            ly_reg <= '0;
        end
        else if (cmd.emit && stored)
        begin
            lp_reg <= touch;
            lx_reg <= px;
            ly_reg <= py;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word.stored  <= stored;
            out_word.pressed <= stored ? touch : lp_reg;
            out_word.x_pos   <= (stored && touch) ? px[11:0] : lx_reg[11:0];
            out_word.y_pos   <= (stored && touch) ? py[11:0] : ly_reg[11:0];
            out_word.raw_x   <= cmd.fail ? 12'd0 : rawx_reg;
            out_word.raw_y   <= cmd.fail ? 12'd0 : rawy_reg;
        end
    end

endmodule

// ===== hw/rtl/touch_sample_filter_and_report_core.sv =====
// Touch sample filter. Takes one 12-bit converter word per handshake in the
// order X burst, Y burst, X burst, Y burst of six samples; a pen-up word ends
// the touch and restarts the order. Each burst is sorted, trimmed and averaged
// by a shared sequencer: after the word that ends a burst come the sort
// passes, the sum, the divide and the save, and no new word is taken until
// they are done; a failed first pair and a pen-up word each add a report. The
// fourth burst adds the two 22-step pixel dividers and the report. A result
// word waits in an output register until taken; the sequencer keeps taking
// words and stalls only when a new result is ready while the previous one
// still waits. Registers are to be written through cfg_we/cfg_idx/cfg_data
// by the user while no word is in flight; the block itself does not enforce it.
module touch_sample_filter_and_report_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [tsfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tsfr_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tsfr_pkg::out_word_t              out_data
);

    tsfr_pkg::cmd_t cmd;
    tsfr_pkg::sts_t sts;

    tsfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_opcode (in_data.opcode),
        .sts       (sts),
        .cmd       (cmd)
    );

    tsfr_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_sample (in_data.sample),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (out_data)
    );

endmodule

// ===== tb/tb_touch_sample_filter_and_report_core.sv =====
`timescale 1ns / 1ps

module tb_touch_sample_filter_and_report_core;

    localparam int BL = tsfr_pkg::BURST_LENGTH;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [tsfr_pkg::CFG_IDX_W-1:0]      cfg_idx;
    logic [tsfr_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    tsfr_pkg::in_word_t                  in_data;
    logic                                out_valid;
    logic                                out_ready;
    tsfr_pkg::out_word_t                 out_data;

    touch_sample_filter_and_report_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    localparam bit OP_SAMPLE = 1'b0;
    localparam bit OP_PEN_UP = 1'b1;
    localparam int SEQ_LEN   = 4 * BL;

    // filter configuration copy
    int unsigned off_x, off_y, div_x, div_y, scr_w, scr_h, agree_win, move_thr;
    // filter state copy
    int unsigned burst_buf [BL];
    int unsigned seq_pos;
    int unsigned pair1_x, pair1_y, pair2_x;
    int unsigned held_press, held_x, held_y;

    tsfr_pkg::out_word_t report_q[$];
    int        mismatches;
    int        items_sent;
    bit        calm;
    int        out_stall;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned adiff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned trimmed_mean();
        int unsigned v [BL];
        int unsigned t;
        int unsigned acc;
        acc = 0;
        v = burst_buf;
        for (int i = 0; i < BL; i++)
        begin
            for (int j = 0; j < BL - 1 - i; j++)
            begin
                if (v[j] > v[j+1])
                begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        for (int i = tsfr_pkg::TRIM_EFF; i < BL - tsfr_pkg::TRIM_EFF; i++)
            acc += v[i];
        return acc / tsfr_pkg::KEEP;
    endfunction

    function automatic int unsigned raw_to_pixel(int unsigned raw, int unsigned off,
                                                 int unsigned dv);
        if (dv == 0)
            return 32'hFFFF_FFFF;
        return adiff(raw, off) * 1000 / dv;
    endfunction

    function automatic tsfr_pkg::out_word_t make_report(bit touch, int unsigned rx,
                                                        int unsigned ry);
        tsfr_pkg::out_word_t r;
        int unsigned px, py;
        bit          st;
        px = 0;
        py = 0;
        if (touch)
        begin
            px = raw_to_pixel(rx, off_x, div_x);
            py = raw_to_pixel(ry, off_y, div_y);
            if (px >= scr_w || py >= scr_h)
            begin
                touch = 1'b0;
                px = 0;
                py = 0;
            end
        end
        st = (held_press != touch) || adiff(held_x, px) > move_thr ||
             adiff(held_y, py) > move_thr;
        if (st)
        begin
            held_press = touch;
            if (touch)
            begin
                held_x = px & 16'hFFFF;
                held_y = py & 16'hFFFF;
            end
        end
        r.stored  = st;
        r.pressed = held_press[0];
        r.x_pos   = held_x[11:0];
        r.y_pos   = held_y[11:0];
        r.raw_x   = rx[11:0];
        r.raw_y   = ry[11:0];
        if (st && !touch)
        begin
            held_x = 0;
            held_y = 0;
        end
        return r;
    endfunction

    // returns 1 with the report when the word causes one
    function automatic bit filter_word(tsfr_pkg::in_word_t w,
                                       output tsfr_pkg::out_word_t r);
        int unsigned burst, avg;
        if (w.opcode == OP_PEN_UP)
        begin
            seq_pos = 0;
            r = make_report(1'b0, 0, 0);
            return 1'b1;
        end
        seq_pos = seq_pos % SEQ_LEN;
        burst_buf[seq_pos % BL] = w.sample;
        seq_pos++;
        if (seq_pos % BL != 0)
            return 1'b0;
        burst = seq_pos / BL;
        avg = trimmed_mean();
        if (burst == 1)
        begin
            pair1_x = avg;
            return 1'b0;
        end
        if (burst == 2)
        begin
            pair1_y = avg;
            if (pair1_x < tsfr_pkg::MIN_RAW || pair1_y < tsfr_pkg::MIN_RAW)
            begin
                seq_pos = 0;
                r = make_report(1'b0, 0, 0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (burst == 3)
        begin
            pair2_x = avg;
            return 1'b0;
        end
        seq_pos = 0;
        if (pair2_x < tsfr_pkg::MIN_RAW || avg < tsfr_pkg::MIN_RAW ||
            adiff(pair1_x, pair2_x) >= agree_win || adiff(pair1_y, avg) >= agree_win)
            r = make_report(1'b0, 0, 0);
        else
            r = make_report(1'b1, (pair1_x + pair2_x) >> 1, (pair1_y + avg) >> 1);
        return 1'b1;
    endfunction

    task automatic write_reg(logic [tsfr_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[15:0];
        case (idx)
            tsfr_pkg::REG_OFFSET_X: off_x     = val & 12'hFFF;
            tsfr_pkg::REG_OFFSET_Y: off_y     = val & 12'hFFF;
            tsfr_pkg::REG_SCALE_X:  div_x     = val & 16'hFFFF;
            tsfr_pkg::REG_SCALE_Y:  div_y     = val & 16'hFFFF;
            tsfr_pkg::REG_SCREEN_W: scr_w     = val & 12'hFFF;
            tsfr_pkg::REG_SCREEN_H: scr_h     = val & 12'hFFF;
            tsfr_pkg::REG_AGREE:    agree_win = val & 12'hFFF;
            tsfr_pkg::REG_MOVE:     move_thr  = val & 12'hFFF;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // send one word; typed set replaces the predicted report
    task automatic send_word(bit op, logic [11:0] smp, bit typed = 0,
                             tsfr_pkg::out_word_t typed_r = '0);
        tsfr_pkg::in_word_t  w;
        tsfr_pkg::out_word_t r;
        int                  gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        w.opcode = op;
        w.sample = smp;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (filter_word(w, r))
            report_q.push_back(typed ? typed_r : r);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [11:0] jitter(int unsigned base);
        int v;
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom_range(0, 4095));
        v = int'(base) + $urandom_range(0, 12) - 6;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    function automatic int unsigned pick_base();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 120);
        return $urandom_range(0, 4095);
    endfunction

    task automatic random_words(int count);
        int          target;
        int unsigned bx, by, sx, sy;
        int          k;
        target = items_sent + count;
        bx = pick_base();
        by = pick_base();
        while (items_sent < target)
        begin
            calm = ($urandom_range(0, 7) == 0);
            k = $urandom_range(0, 11);
            if (k == 0)
                send_word(OP_PEN_UP, 12'($urandom_range(0, 4095)));
            else if (k == 1)
            begin
                repeat ($urandom_range(1, SEQ_LEN - 1))
                    send_word(OP_SAMPLE, 12'($urandom_range(0, 4095)));
                send_word(OP_PEN_UP, 12'($urandom_range(0, 4095)));
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    bx = pick_base();
                    by = pick_base();
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    bx = (bx + $urandom_range(0, 400)) % 4096;
                    by = (by + $urandom_range(0, 400)) % 4096;
                end
                sx = (bx + $urandom_range(0, 30)) % 4096;
                sy = (by + $urandom_range(0, 30)) % 4096;
                for (int i = 0; i < SEQ_LEN; i++)
                begin
                    case (i / BL)
                        0: send_word(OP_SAMPLE, jitter(bx));
                        1: send_word(OP_SAMPLE, jitter(by));
                        2: send_word(OP_SAMPLE, jitter(sx));
                        default: send_word(OP_SAMPLE, jitter(sy));
                    endcase
                end
            end
        end
        calm = 1'b0;
    endtask

    task automatic set_all(int unsigned ox, int unsigned oy, int unsigned dx,
                           int unsigned dy, int unsigned w, int unsigned h,
                           int unsigned ag, int unsigned mv);
        write_reg(tsfr_pkg::REG_OFFSET_X, ox);
        write_reg(tsfr_pkg::REG_OFFSET_Y, oy);
        write_reg(tsfr_pkg::REG_SCALE_X, dx);
        write_reg(tsfr_pkg::REG_SCALE_Y, dy);
        write_reg(tsfr_pkg::REG_SCREEN_W, w);
        write_reg(tsfr_pkg::REG_SCREEN_H, h);
        write_reg(tsfr_pkg::REG_AGREE, ag);
        write_reg(tsfr_pkg::REG_MOVE, mv);
    endtask

    // directed rows
    typedef struct {
        bit                  op;
        logic [11:0]         smp;
        bit                  typed;
        tsfr_pkg::out_word_t r;
    } stim_row_t;

    stim_row_t stim_rows[$];

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        calm      = 1'b0;
        mismatches = 0;
        items_sent = 0;
        off_x = 247; off_y = 3388; div_x = 4421; div_y = 6078;
        scr_w = 800; scr_h = 480; agree_win = 20; move_thr = 30;
        seq_pos = 0; pair1_x = 0; pair1_y = 0; pair2_x = 0;
        held_press = 0; held_x = 0; held_y = 0;
        for (int i = 0; i < BL; i++)
            burst_buf[i] = 0;

        // pen up after reset, failed first pair, full-scale samples, pen up
        stim_rows.push_back('{OP_PEN_UP, 12'hFFF, 1'b1, '0});
        for (int i = 0; i < 2 * BL; i++)
            stim_rows.push_back('{OP_SAMPLE, 12'h000, i == 2 * BL - 1, '0});
        for (int i = 0; i < 2 * BL; i++)
            stim_rows.push_back('{OP_SAMPLE, 12'hFFF, 1'b0, '0});
        stim_rows.push_back('{OP_PEN_UP, 12'h000, 1'b1, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_word(stim_rows[i].op, stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].r);

        random_words(190);
        drain();
        set_all($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 9000),
                $urandom_range(1, 9000), $urandom_range(1, 4095), $urandom_range(1, 4095),
                $urandom_range(1, 200), $urandom_range(0, 100));
        random_words(190);
        drain();
        set_all(0, 4095, 1, 65535, 4095, 4095, 4095, 0);
        random_words(150);
        drain();
        set_all(4095, 0, 65535, 1, 4095, 4095, 1, 4095);
        random_words(150);
        drain();
        set_all(2000, 2000, 0, 3000, 0, 4095, 0, 10);
        random_words(80);
        drain();
        set_all(0, 0, 65535, 65535, 4095, 4095, 60, 0);
        random_words(190);
        drain();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (report_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", out_data);
            end
            else
            begin
                if (out_data !== report_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("exp st=%0d pr=%0d x=%0d y=%0d rx=%0d ry=%0d",
                                 report_q[0].stored, report_q[0].pressed,
                                 report_q[0].x_pos, report_q[0].y_pos,
                                 report_q[0].raw_x, report_q[0].raw_y);
                        $display("got st=%0d pr=%0d x=%0d y=%0d rx=%0d ry=%0d",
                                 out_data.stored, out_data.pressed, out_data.x_pos,
                                 out_data.y_pos, out_data.raw_x, out_data.raw_y);
                    end
                end
                void'(report_q.pop_front());
            end
            if (!calm)
            begin
                out_stall <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
        end
        else if (!out_ready)
        begin
            if (out_stall == 0)
                out_ready <= 1'b1;
            else
                out_stall <= out_stall - 1;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/tsfr_pkg.sv
hw/rtl/tsfr_ctrl.sv
hw/rtl/tsfr_dp.sv
hw/rtl/touch_sample_filter_and_report_core.sv
tb/tb_touch_sample_filter_and_report_core.sv
